@@ src/rmp_pkg.sv @@
// Shared types and constants for the region mass properties block.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none
package rmp_pkg;

  localparam int COORD_BITS = 16;
  localparam int AREA_W     = 44;
  localparam int LEN_W      = 40;
  localparam int SUM_W      = 64;
  localparam int EPS_W      = 32;

  localparam logic signed [SUM_W:0] SUM_MAX = 65'sh07FFFFFFFFFFFFFFF;
  localparam logic signed [SUM_W:0] SUM_MIN = -SUM_MAX;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BOX, ST_M1, ST_M2, ST_CR, ST_MX, ST_MY, ST_DX, ST_DY,
    ST_SQ, ST_SQW, ST_LOOPCHK, ST_RA, ST_RMX, ST_RMY, ST_CLR, ST_FIN,
    ST_DIVX, ST_DWX, ST_DIVY, ST_DWY, ST_OUT
  } state_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    coord_t            centroid_x;
    coord_t            centroid_y;
    logic              centroid_valid;
    logic [LEN_W-1:0]  perimeter;
    coord_t            box_min_x;
    coord_t            box_min_y;
    coord_t            box_max_x;
    coord_t            box_max_y;
    logic              overflow;
  } result_t;

endpackage
`default_nettype wire

@@ src/rmp_if.sv @@
// Channel interfaces: vertex requests, region results, config writes.
// Depends on rmp_pkg.
`default_nettype none
interface rmp_vertex_if import rmp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_in_loop;
  logic   last_in_region;
  modport source (output valid, vertex_x, vertex_y, last_in_loop, last_in_region,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, last_in_loop, last_in_region,
                output ready);
endinterface

interface rmp_result_if import rmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] area;
  coord_t            centroid_x;
  coord_t            centroid_y;
  logic              centroid_valid;
  logic [LEN_W-1:0]  perimeter;
  coord_t            box_min_x;
  coord_t            box_min_y;
  coord_t            box_max_x;
  coord_t            box_max_y;
  logic              overflow;
  modport source (output valid, area, centroid_x, centroid_y, centroid_valid, perimeter,
                  box_min_x, box_min_y, box_max_x, box_max_y, overflow, input ready);
  modport sink (input valid, area, centroid_x, centroid_y, centroid_valid, perimeter,
                box_min_x, box_min_y, box_max_x, box_max_y, overflow, output ready);
endinterface

interface rmp_cfg_if import rmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/rmp_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on rmp_pkg.
`default_nettype none
module rmp_sqrt import rmp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [33:0] value,
  output logic [16:0]      root,
  output logic             busy
);
  logic [33:0] v;
  logic [34:0] r;
  logic [33:0] bitv;
  logic [34:0] trial;

  assign trial = r + {1'b0, bitv};
  assign root  = r[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitv[0]) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      r    <= '0;
      bitv <= 34'h1 << 32;
    end else if (busy) begin
      if ({1'b0, v} >= trial) begin
        v <= v - trial[33:0];
        r <= (r >> 1) + {1'b0, bitv};
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end
endmodule
`default_nettype wire

@@ src/rmp_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on rmp_pkg.
`default_nettype none
module rmp_div import rmp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [SUM_W:0]   divisor,
  output logic [SUM_W-1:0]      quotient,
  output logic                  busy
);
  logic [SUM_W:0]   rem;
  logic [SUM_W-1:0] num;
  logic [SUM_W:0]   dvs;
  logic [5:0]       cnt;
  logic [SUM_W+1:0] trial;
  logic             take;

  assign trial    = {rem, num[SUM_W-1]};
  assign take     = trial >= {1'b0, dvs};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '1;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd0) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? 65'(trial - {1'b0, dvs}) : trial[SUM_W:0];
      num <= {num[SUM_W-2:0], take};
    end
  end
endmodule
`default_nettype wire

@@ src/region_mass_properties.sv @@
// Region mass properties: shoelace area, centroid, perimeter, bounding box.
// Depends on rmp_pkg, rmp_if, rmp_sqrt, rmp_div.
//
// Vertices arrive on the vertex channel, one request at a time, each flagged
// for end of loop and end of region. A sequencer runs one shared multiplier
// and one saturating 64-bit adder over each edge, and an iterative square
// root for its length. A vertex that opens a loop it does not close runs no
// edge; one that closes a loop runs its closing edge through the same
// sequence again, then the loop is folded into the region sums if it has at
// least three vertices. At region end two divisions form the centroid; they
// are skipped when the doubled area is within epsilon. vertex.ready is high
// only while the sequencer is idle. One result per region goes to an output
// register; the next region's vertices are taken while it waits, and only
// the next region end stalls until the receiver takes it. cfg writes
// area_epsilon, always ready; write it only while idle. Synchronous reset
// clears all sums, the box, the epsilon register and the output valid.
`default_nettype none
module region_mass_properties import rmp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  rmp_vertex_if.sink    vertex,
  rmp_result_if.source  result,
  rmp_cfg_if.sink       cfg
);
  state_t state, state_next;

  logic [EPS_W-1:0] eps;
  coord_t cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic end_loop, end_region, closing, region_open, sat;
  logic [1:0] loop_count;
  logic signed [SUM_W-1:0] loop_a2, loop_mx, loop_my, reg_a2, reg_mx, reg_my;
  logic [LEN_W-1:0] loop_len, reg_len;
  coord_t box_min_x, box_min_y, box_max_x, box_max_y;
  coord_t ea_x, ea_y, eb_x, eb_y;
  logic signed [49:0] prod, t1;
  logic signed [32:0] cross_p;
  logic [SUM_W:0] d3;
  logic a2neg, cvalid, ovf_r;
  logic [AREA_W-1:0] area_r;
  coord_t cx, cy;
  result_t res;
  logic res_v;

  logic signed [16:0] mul_a, dx, dy, sx, sy;
  logic signed [32:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [SUM_W-1:0] add_a, add_b, add_res;
  logic signed [SUM_W:0] add_s;
  logic add_ovf;
  logic [LEN_W-1:0] len_a, len_b, len_res;
  logic [LEN_W:0] len_s;
  logic [SUM_W-1:0] ra_mag, la_mag;
  logic sq_start, sq_busy, dv_start, dv_busy, take_in, out_free;
  logic [16:0] sq_root;
  logic [SUM_W-1:0] dv_num, dv_q;

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  function automatic coord_t clampq(input logic [SUM_W-1:0] q, input logic neg);
    logic [SUM_W-1:0] lim;
    lim = SUM_W'(1) << (COORD_BITS - 1);
    if (neg) clampq = (q >= lim) ? coord_t'(-lim) : coord_t'(-q);
    else     clampq = (q >= lim - 1) ? coord_t'(lim - 1) : coord_t'(q);
  endfunction

  assign take_in  = vertex.valid && vertex.ready;
  assign out_free = !res_v || result.ready;
  assign vertex.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign dx = {eb_x[15], eb_x} - {ea_x[15], ea_x};
  assign dy = {eb_y[15], eb_y} - {ea_y[15], ea_y};
  assign sx = {ea_x[15], ea_x} + {eb_x[15], eb_x};
  assign sy = {ea_y[15], ea_y} + {eb_y[15], eb_y};
  assign mul_p = mul_a * mul_b;

  assign add_s = {add_a[SUM_W-1], add_a} + {add_b[SUM_W-1], add_b};
  always_comb begin
    add_ovf = 1'b0;
    add_res = add_s[SUM_W-1:0];
    if (add_s > SUM_MAX) begin
      add_ovf = 1'b1;
      add_res = SUM_MAX[SUM_W-1:0];
    end else if (add_s < SUM_MIN) begin
      add_ovf = 1'b1;
      add_res = SUM_MIN[SUM_W-1:0];
    end
  end

  assign len_s   = {1'b0, len_a} + {1'b0, len_b};
  assign len_res = len_s[LEN_W] ? '1 : len_s[LEN_W-1:0];
  assign ra_mag  = mag(reg_a2);
  assign la_mag  = mag(loop_a2);

  // operand selection
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    add_a    = '0;
    add_b    = '0;
    len_a    = loop_len;
    len_b    = {23'd0, sq_root};
    sq_start = 1'b0;
    dv_start = 1'b0;
    dv_num   = mag(reg_mx);
    case (state)
      ST_M1: begin
        mul_a = {ea_x[15], ea_x};
        mul_b = {{17{eb_y[15]}}, eb_y};
      end
      ST_M2: begin
        mul_a = {eb_x[15], eb_x};
        mul_b = {{17{ea_y[15]}}, ea_y};
      end
      ST_MX: begin
        mul_a = sx;
        mul_b = cross_p;
        add_a = loop_a2;
        add_b = {{31{cross_p[32]}}, cross_p};
      end
      ST_MY: begin
        mul_a = sy;
        mul_b = cross_p;
        add_a = loop_mx;
        add_b = {{14{prod[49]}}, prod};
      end
      ST_DX: begin
        mul_a = dx;
        mul_b = {{16{dx[16]}}, dx};
        add_a = loop_my;
        add_b = {{14{prod[49]}}, prod};
      end
      ST_DY: begin
        mul_a = dy;
        mul_b = {{16{dy[16]}}, dy};
      end
      ST_SQ: sq_start = 1'b1;
      ST_RA: begin
        add_a = reg_a2;
        add_b = loop_a2;
        len_a = reg_len;
        len_b = loop_len;
      end
      ST_RMX: begin
        add_a = reg_mx;
        add_b = loop_mx;
      end
      ST_RMY: begin
        add_a = reg_my;
        add_b = loop_my;
      end
      ST_DIVX: dv_start = 1'b1;
      ST_DIVY: begin
        dv_start = 1'b1;
        dv_num   = mag(reg_my);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (take_in) state_next = ST_BOX;
      ST_BOX:     state_next = (loop_count == 2'd0) ? ST_LOOPCHK : ST_M1;
      ST_M1:      state_next = ST_M2;
      ST_M2:      state_next = ST_CR;
      ST_CR:      state_next = ST_MX;
      ST_MX:      state_next = ST_MY;
      ST_MY:      state_next = ST_DX;
      ST_DX:      state_next = ST_DY;
      ST_DY:      state_next = ST_SQ;
      ST_SQ:      state_next = ST_SQW;
      ST_SQW: begin
        if (!sq_busy) begin
          if (!closing) state_next = ST_LOOPCHK;
          else state_next = (loop_count == 2'd3) ? ST_RA : ST_CLR;
        end
      end
      ST_LOOPCHK: state_next = end_loop ? ST_M1 : ST_IDLE;
      ST_RA:      state_next = (la_mag > SUM_W'(eps)) ? ST_RMX : ST_CLR;
      ST_RMX:     state_next = ST_RMY;
      ST_RMY:     state_next = ST_CLR;
      ST_CLR:     state_next = end_region ? ST_FIN : ST_IDLE;
      ST_FIN:     state_next = (ra_mag > SUM_W'(eps)) ? ST_DIVX : ST_OUT;
      ST_DIVX:    state_next = ST_DWX;
      ST_DWX:     if (!dv_busy) state_next = ST_DIVY;
      ST_DIVY:    state_next = ST_DWY;
      ST_DWY:     if (!dv_busy) state_next = ST_OUT;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= '0;
    end else if (cfg.valid) begin
      eps <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      res_v <= 1'b1;
    end else if (result.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x <= '0; first_y <= '0; prev_x <= '0; prev_y <= '0;
      loop_count <= '0;
      loop_a2 <= '0; loop_mx <= '0; loop_my <= '0; loop_len <= '0;
      reg_a2 <= '0; reg_mx <= '0; reg_my <= '0; reg_len <= '0;
      box_min_x <= '0; box_min_y <= '0; box_max_x <= '0; box_max_y <= '0;
      sat <= 1'b0;
      region_open <= 1'b0;
      end_loop <= 1'b0;
      end_region <= 1'b0;
      closing <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take_in) begin
            end_region <= vertex.last_in_region;
            end_loop   <= vertex.last_in_loop || vertex.last_in_region;
          end
        end
        ST_BOX: begin
          region_open <= 1'b1;
          if (!region_open) begin
            box_min_x <= cur_x; box_max_x <= cur_x;
            box_min_y <= cur_y; box_max_y <= cur_y;
          end else begin
            if (cur_x < box_min_x) box_min_x <= cur_x;
            if (cur_y < box_min_y) box_min_y <= cur_y;
            if (cur_x > box_max_x) box_max_x <= cur_x;
            if (cur_y > box_max_y) box_max_y <= cur_y;
          end
          if (loop_count == 2'd0) begin
            first_x <= cur_x;
            first_y <= cur_y;
          end
          if (loop_count != 2'd3) loop_count <= loop_count + 2'd1;
          prev_x <= cur_x;
          prev_y <= cur_y;
          closing <= 1'b0;
        end
        ST_MX: begin
          loop_a2 <= add_res;
          if (add_ovf) sat <= 1'b1;
        end
        ST_MY: begin
          loop_mx <= add_res;
          if (add_ovf) sat <= 1'b1;
        end
        ST_DX: begin
          loop_my <= add_res;
          if (add_ovf) sat <= 1'b1;
        end
        ST_SQW: begin
          if (!sq_busy) begin
            loop_len <= len_res;
            if (len_s[LEN_W]) sat <= 1'b1;
          end
        end
        ST_LOOPCHK: closing <= 1'b1;
        ST_RA: begin
          reg_a2  <= add_res;
          reg_len <= len_res;
          if (add_ovf || len_s[LEN_W]) sat <= 1'b1;
        end
        ST_RMX: begin
          reg_mx <= add_res;
          if (add_ovf) sat <= 1'b1;
        end
        ST_RMY: begin
          reg_my <= add_res;
          if (add_ovf) sat <= 1'b1;
        end
        ST_CLR: begin
          first_x <= '0; first_y <= '0;
          loop_count <= '0;
          loop_a2 <= '0; loop_mx <= '0; loop_my <= '0; loop_len <= '0;
        end
        ST_OUT: begin
          if (out_free) begin
            prev_x <= '0; prev_y <= '0;
            reg_a2 <= '0; reg_mx <= '0; reg_my <= '0; reg_len <= '0;
            box_min_x <= '0; box_min_y <= '0; box_max_x <= '0; box_max_y <= '0;
            sat <= 1'b0;
            region_open <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_x <= vertex.vertex_x;
        cur_y <= vertex.vertex_y;
      end
      ST_BOX: begin
        ea_x <= prev_x; ea_y <= prev_y;
        eb_x <= cur_x;  eb_y <= cur_y;
      end
      ST_LOOPCHK: begin
        ea_x <= cur_x;   ea_y <= cur_y;
        eb_x <= first_x; eb_y <= first_y;
      end
      ST_M1: prod <= mul_p;
      ST_M2: begin
        t1   <= prod;
        prod <= mul_p;
      end
      ST_CR: cross_p <= t1[32:0] - prod[32:0];
      ST_MX, ST_MY, ST_DX: prod <= mul_p;
      ST_DY: begin
        t1   <= prod;
        prod <= mul_p;
      end
      ST_FIN: begin
        d3     <= {ra_mag, 1'b0} + {1'b0, ra_mag};
        a2neg  <= reg_a2[SUM_W-1];
        cvalid <= ra_mag > SUM_W'(eps);
        cx     <= '0;
        cy     <= '0;
        if (ra_mag[SUM_W-1:AREA_W+1] != '0) begin
          area_r <= '1;
          ovf_r  <= 1'b1;
        end else begin
          area_r <= ra_mag[AREA_W:1];
          ovf_r  <= sat;
        end
      end
      ST_DWX: if (!dv_busy) cx <= clampq(dv_q, reg_mx[SUM_W-1] != a2neg);
      ST_DWY: if (!dv_busy) cy <= clampq(dv_q, reg_my[SUM_W-1] != a2neg);
      ST_OUT: begin
        if (out_free) begin
          res.area           <= area_r;
          res.centroid_x     <= cx;
          res.centroid_y     <= cy;
          res.centroid_valid <= cvalid;
          res.perimeter      <= reg_len;
          res.box_min_x      <= box_min_x;
          res.box_min_y      <= box_min_y;
          res.box_max_x      <= box_max_x;
          res.box_max_y      <= box_max_y;
          res.overflow       <= ovf_r;
        end
      end
      default: ;
    endcase
  end

  rmp_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (t1[33:0] + prod[33:0]),
    .root  (sq_root),
    .busy  (sq_busy)
  );

  rmp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (d3),
    .quotient (dv_q),
    .busy     (dv_busy)
  );

  assign result.valid          = res_v;
  assign result.area           = res.area;
  assign result.centroid_x     = res.centroid_x;
  assign result.centroid_y     = res.centroid_y;
  assign result.centroid_valid = res.centroid_valid;
  assign result.perimeter      = res.perimeter;
  assign result.box_min_x      = res.box_min_x;
  assign result.box_min_y      = res.box_min_y;
  assign result.box_max_x      = res.box_max_x;
  assign result.box_max_y      = res.box_max_y;
  assign result.overflow       = res.overflow;
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for region_mass_properties: random and directed polygon regions.
// Scoreboard predicts area, centroid, perimeter and box per region end.
// Depends on rmp_pkg, rmp_if and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import rmp_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     lil;
    bit     lir;
  } vtx_t;

  class region_scoreboard;
    bit [EPS_W-1:0]    eps;
    longint            fx, fy, px, py;
    int                lcnt;
    longint            la2, lmx, lmy;
    longint unsigned   llen;
    longint            ra2, rmx, rmy;
    longint unsigned   rlen;
    longint            bmin_x, bmin_y, bmax_x, bmax_y;
    bit                sat, open;
    result_t           pending_q[$];
    int                errors;

    function void clear_loop();
      fx = 0; fy = 0; lcnt = 0; la2 = 0; lmx = 0; lmy = 0; llen = 0;
    endfunction

    function void clear_region();
      clear_loop();
      px = 0; py = 0; ra2 = 0; rmx = 0; rmy = 0; rlen = 0;
      bmin_x = 0; bmin_y = 0; bmax_x = 0; bmax_y = 0;
      sat = 0; open = 0;
    endfunction

    function new();
      eps = 0;
      errors = 0;
      clear_region();
    endfunction

    function longint sum_sat(longint a, longint b);
      longint mx;
      mx = 64'sh7FFFFFFFFFFFFFFF;
      if (b > 0 && a > mx - b) begin
        sat = 1; return mx;
      end
      if (b < 0 && a < -mx - b) begin
        sat = 1; return -mx;
      end
      return a + b;
    endfunction

    function longint unsigned len_sat(longint unsigned a, longint unsigned b);
      longint unsigned mx;
      mx = (64'd1 << LEN_W) - 1;
      if (a > mx || b > mx - a) begin
        sat = 1; return mx;
      end
      return a + b;
    endfunction

    function longint unsigned magnitude(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void edge_sum(longint ax, longint ay, longint bx, longint by);
      longint cr, dx, dy;
      cr = ax * by - bx * ay;
      dx = bx - ax;
      dy = by - ay;
      la2 = sum_sat(la2, cr);
      lmx = sum_sat(lmx, (ax + bx) * cr);
      lmy = sum_sat(lmy, (ay + by) * cr);
      llen = len_sat(llen, int_sqrt(longint'(dx * dx) + longint'(dy * dy)));
    endfunction

    function coord_t centroid_of(longint m, longint unsigned a2m, bit a2neg);
      longint unsigned q;
      bit neg;
      q = (magnitude(m) / a2m) / 3;
      neg = (m < 0) != a2neg;
      if (neg) return q >= 32768 ? -16'sd32768 : coord_t'(-longint'(q));
      return q >= 32767 ? 16'sd32767 : coord_t'(q);
    endfunction

    function void note_vertex(vtx_t v);
      longint x, y;
      bit end_loop;
      longint unsigned a2m, ar;
      result_t r;
      x = v.x;
      y = v.y;
      end_loop = v.lil || v.lir;
      if (!open) begin
        bmin_x = x; bmax_x = x; bmin_y = y; bmax_y = y; open = 1;
      end else begin
        if (x < bmin_x) bmin_x = x;
        if (y < bmin_y) bmin_y = y;
        if (x > bmax_x) bmax_x = x;
        if (y > bmax_y) bmax_y = y;
      end
      if (lcnt == 0) begin
        fx = x; fy = y;
      end else begin
        edge_sum(px, py, x, y);
      end
      if (lcnt < 3) lcnt++;
      px = x;
      py = y;
      if (end_loop) begin
        edge_sum(x, y, fx, fy);
        if (lcnt >= 3) begin
          ra2 = sum_sat(ra2, la2);
          rlen = len_sat(rlen, llen);
          if (magnitude(la2) > longint'(eps)) begin
            rmx = sum_sat(rmx, lmx);
            rmy = sum_sat(rmy, lmy);
          end
        end
        clear_loop();
      end
      if (!v.lir) return;
      a2m = magnitude(ra2);
      r.centroid_valid = a2m > longint'(eps);
      r.centroid_x = 0;
      r.centroid_y = 0;
      if (r.centroid_valid) begin
        r.centroid_x = centroid_of(rmx, a2m, ra2 < 0);
        r.centroid_y = centroid_of(rmy, a2m, ra2 < 0);
      end
      ar = a2m >> 1;
      r.overflow = sat;
      if (ar > (64'd1 << AREA_W) - 1) begin
        ar = (64'd1 << AREA_W) - 1;
        r.overflow = 1;
      end
      r.area = ar[AREA_W-1:0];
      r.perimeter = rlen[LEN_W-1:0];
      r.box_min_x = coord_t'(bmin_x);
      r.box_min_y = coord_t'(bmin_y);
      r.box_max_x = coord_t'(bmax_x);
      r.box_max_y = coord_t'(bmax_y);
      pending_q.push_back(r);
      clear_region();
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected region result area=%0d", got.area);
        return;
      end
      e = pending_q.pop_front();
      if (got.area !== e.area || got.centroid_x !== e.centroid_x ||
          got.centroid_y !== e.centroid_y || got.centroid_valid !== e.centroid_valid ||
          got.perimeter !== e.perimeter || got.box_min_x !== e.box_min_x ||
          got.box_min_y !== e.box_min_y || got.box_max_x !== e.box_max_x ||
          got.box_max_y !== e.box_max_y || got.overflow !== e.overflow) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: exp area=%0d cx=%0d cy=%0d cv=%0b per=%0d box=%0d,%0d,%0d,%0d ovf=%0b",
                   e.area, e.centroid_x, e.centroid_y, e.centroid_valid, e.perimeter,
                   e.box_min_x, e.box_min_y, e.box_max_x, e.box_max_y, e.overflow);
          $display("       got area=%0d cx=%0d cy=%0d cv=%0b per=%0d box=%0d,%0d,%0d,%0d ovf=%0b",
                   got.area, got.centroid_x, got.centroid_y, got.centroid_valid,
                   got.perimeter, got.box_min_x, got.box_min_y, got.box_max_x,
                   got.box_max_y, got.overflow);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;

  rmp_vertex_if vertex ();
  rmp_result_if result ();
  rmp_cfg_if    cfg ();

  region_mass_properties i_dut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex.sink),
    .result (result.source),
    .cfg    (cfg.sink)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  region_scoreboard sb = new();
  int send_idle = 8;
  int recv_idle = 65;
  int hold_req  = 0;
  int hold_cnt  = 0;
  int quiet     = 0;
  int sent      = 0;

  initial begin
    vertex.valid = 0;
    vertex.vertex_x = 0;
    vertex.vertex_y = 0;
    vertex.last_in_loop = 0;
    vertex.last_in_region = 0;
    result.ready = 0;
    cfg.valid = 0;
    cfg.data = 0;
  end

  // receiver: random stalls plus long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
      result.ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      result.ready <= 0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && result.valid && result.ready) begin
      got.area = result.area;
      got.centroid_x = result.centroid_x;
      got.centroid_y = result.centroid_y;
      got.centroid_valid = result.centroid_valid;
      got.perimeter = result.perimeter;
      got.box_min_x = result.box_min_x;
      got.box_min_y = result.box_min_y;
      got.box_max_x = result.box_max_x;
      got.box_max_y = result.box_max_y;
      got.overflow = result.overflow;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (vertex.valid && vertex.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet > 40000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_vertex(vtx_t v);
    if ($urandom_range(99) < send_idle) begin
      vertex.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    vertex.valid <= 1;
    vertex.vertex_x <= v.x;
    vertex.vertex_y <= v.y;
    vertex.last_in_loop <= v.lil;
    vertex.last_in_region <= v.lir;
    do @(posedge clk); while (!vertex.ready);
    sb.note_vertex(v);
    sent++;
  endtask

  task automatic send_xy(int x, int y, bit lil, bit lir);
    vtx_t v;
    v.x = coord_t'(x);
    v.y = coord_t'(y);
    v.lil = lil;
    v.lir = lir;
    send_vertex(v);
  endtask

  task automatic write_epsilon(bit [EPS_W-1:0] val);
    vertex.valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg.valid <= 1;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    sb.eps = val;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return coord_t'($urandom());
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      2: return coord_t'($urandom_range(0, 65535));
      default: return coord_t'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic random_region();
    int nl, nv;
    vtx_t v;
    nl = $urandom_range(1, 3);
    for (int l = 0; l < nl; l++) begin
      case ($urandom_range(9))
        0: nv = $urandom_range(1, 2);
        1: nv = $urandom_range(9, 20);
        default: nv = $urandom_range(3, 8);
      endcase
      for (int k = 0; k < nv; k++) begin
        v.x = rand_coord();
        v.y = rand_coord();
        v.lil = (k == nv - 1);
        v.lir = 0;
        if (k == nv - 1 && l == nl - 1) begin
          v.lir = 1;
          v.lil = $urandom_range(1);
        end else if ($urandom_range(49) == 0) begin
          v.lil = ~v.lil;
        end
        send_vertex(v);
      end
    end
  endtask

  initial begin
    bit [EPS_W-1:0] eps_set[4];
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_epsilon(0);
    // square, then extreme corners
    send_xy(0, 0, 0, 0); send_xy(256, 0, 0, 0); send_xy(256, 256, 0, 0);
    send_xy(0, 256, 1, 1);
    send_xy(-32768, -32768, 0, 0); send_xy(32767, -32768, 0, 0);
    send_xy(32767, 32767, 0, 0); send_xy(-32768, 32767, 0, 1);
    // single vertex region, two-vertex loop
    send_xy(100, -100, 1, 1);
    send_xy(5, 5, 0, 0); send_xy(-5, 9, 1, 1);
    // cw outer loop with a nearly equal ccw hole: nearly canceling loops (centroid clamp)
    send_xy(30000, 30000, 0, 0); send_xy(30000, 30512, 0, 0);
    send_xy(30512, 30512, 1, 0);
    send_xy(30000, 30000, 0, 0); send_xy(30511, 30512, 0, 0);
    send_xy(30000, 30512, 1, 1);
    // degenerate collinear loop
    send_xy(0, 0, 0, 0); send_xy(10, 10, 0, 0); send_xy(20, 20, 1, 1);

    write_epsilon(32'hFFFFFFFF);
    send_xy(0, 0, 0, 0); send_xy(-32768, 0, 0, 0); send_xy(0, 32767, 0, 1);

    eps_set[0] = 32'hFFFFFFFF;
    eps_set[1] = 32'h0001_0000;
    eps_set[2] = $urandom();
    eps_set[3] = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_epsilon(eps_set[ph]);
      case (ph)
        0: begin send_idle = 8;  recv_idle = 65; end
        1: begin send_idle = 65; recv_idle = 8;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == 2) hold_req = 3000;
      while (sent < 25 + 215 * (ph + 1)) random_region();
    end
    vertex.valid <= 0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rmp_pkg.sv
src/rmp_if.sv
src/rmp_sqrt.sv
src/rmp_div.sv
src/region_mass_properties.sv
tb/tb_top.sv
